[rtl/planning_tree_nearest_grow_core_macros.svh]
// Assertion macros shared by the checker file
`ifndef PLANNING_TREE_NEAREST_GROW_CORE_MACROS_SVH
`define PLANNING_TREE_NEAREST_GROW_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PTNG_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define PTNG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/ptng_pkg.sv]
// Types and constants of the planning tree nearest-grow block
`default_nettype none
package ptng_pkg;
  typedef logic signed [14:0] coord_t;
  typedef logic [2:0] kind_t;

  localparam kind_t KIND_ROOT    = 3'd0;
  localparam kind_t KIND_ADDED   = 3'd1;
  localparam kind_t KIND_PATH    = 3'd2;
  localparam kind_t KIND_IGNORED = 3'd3;
  localparam kind_t KIND_FULL    = 3'd4;

  localparam logic [1:0] REG_GOAL_X        = 2'd0;
  localparam logic [1:0] REG_GOAL_Y        = 2'd1;
  localparam logic [1:0] REG_GOAL_RADIUS   = 2'd2;
  localparam logic [1:0] REG_NEAREST_LIMIT = 2'd3;

  localparam logic [14:0] GOAL_RADIUS_RESET   = 15'd640;
  localparam logic [15:0] NEAREST_LIMIT_RESET = 16'hFFFF;

  // Sample travelling along the cell row with the best match so far
  typedef struct packed {
    logic        vld;
    coord_t      px;
    coord_t      py;
    logic [15:0] bestd;
    logic [5:0]  best;
  } probe_t;
endpackage
`default_nettype wire

[rtl/ptng_ram.sv]
// Generic single-port-write RAM with registered read
`default_nettype none
module ptng_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

[rtl/ptng_cell.sv]
// One tree node cell: holds a point and updates the passing nearest match
`default_nettype none
module ptng_cell #(
  parameter int INDEX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            enable,
  input  logic            wr_en,
  input  ptng_pkg::coord_t wr_x,
  input  ptng_pkg::coord_t wr_y,
  input  ptng_pkg::probe_t prev,
  output ptng_pkg::probe_t nxt
);
  import ptng_pkg::*;

  coord_t             x;
  coord_t             y;
  logic signed [15:0] dx;
  logic signed [15:0] dy;
  logic [15:0]        adx;
  logic [15:0]        ady;
  logic [16:0]        d;
  logic               take;

  always_comb begin
    dx   = 16'(prev.px) - 16'(x);
    dy   = 16'(prev.py) - 16'(y);
    adx  = dx[15] ? 16'(-dx) : 16'(dx);
    ady  = dy[15] ? 16'(-dy) : 16'(dy);
    d    = {1'b0, adx} + {1'b0, ady};
    take = enable && (d < {1'b0, prev.bestd});
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      x <= wr_x;
      y <= wr_y;
    end
    nxt.px <= prev.px;
    nxt.py <= prev.py;
    nxt.bestd <= take ? d[15:0] : prev.bestd;
    nxt.best <= take ? 6'(INDEX) : prev.best;
    if (rst) begin
      nxt.vld <= 1'b0;
    end else begin
      nxt.vld <= prev.vld;
    end
  end
endmodule
`default_nettype wire

[rtl/planning_tree_nearest_grow_core.sv]
// Top level of the planning tree nearest-grow block
//
//  channel  direction  handshake              payload
//  in       in         in_valid / in_ready    operation, point_x, point_y
//  out      out        out_valid / out_ready  kind, node_index, parent_index,
//                                             node_x, node_y, goal_reached, last
//  cfg      in         cfg_we                 cfg_index, cfg_data
//
// A start, ignored or full transaction shows its result in the cycle after it is accepted.
// An add runs the sample through the MAX_NODES-cell row to its result; each path node
// then goes through a node RAM read (S_RD) and an output register (S_DATA).
// One transaction is in flight at a time; a stalled output holds everything.
// Reset clears the tree (no node) and the goal flag, and sets the registers to their reset values.
`default_nettype none
module planning_tree_nearest_grow_core #(
  parameter int MAX_NODES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  ptng_pkg::coord_t  point_x,
  input  ptng_pkg::coord_t  point_y,
  output logic              out_valid,
  input  logic              out_ready,
  output ptng_pkg::kind_t   kind,
  output logic [5:0]        node_index,
  output logic [5:0]        parent_index,
  output ptng_pkg::coord_t  node_x,
  output ptng_pkg::coord_t  node_y,
  output logic              goal_reached,
  output logic              last
);
  import ptng_pkg::*;

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int RAM_W = 30 + IDX_W;

  typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_EMIT, S_RD, S_DATA} state_t;

  state_t             state;
  coord_t             goal_x;
  coord_t             goal_y;
  logic [14:0]        goal_radius;
  logic [15:0]        nearest_limit;
  logic [CNT_W-1:0]   node_count;
  logic               goal_done;
  coord_t             sx;
  coord_t             sy;
  logic [IDX_W-1:0]   walk_i;
  logic               walk_more;
  logic [CNT_W-1:0]   n_out;

  probe_t             chain [MAX_NODES+1];
  logic               accept;
  logic               root_wr;
  logic               leaf_wr;
  logic [IDX_W-1:0]   leaf;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [RAM_W-1:0]   ram_wdata;
  logic [RAM_W-1:0]   ram_rdata;
  logic [IDX_W-1:0]   rd_parent;
  logic signed [15:0] gdx;
  logic signed [15:0] gdy;
  logic [16:0]        gdist;
  logic               goal_hit;
  logic               path_end;
  logic [CNT_W:0]     n_plus;

  assign in_ready = (state == S_IDLE) && !rst;
  assign accept   = in_valid && in_ready;
  assign root_wr  = accept && !operation;
  assign leaf_wr  = (state == S_SEARCH) && chain[MAX_NODES].vld;
  assign leaf     = node_count[IDX_W-1:0];

  always_comb begin
    chain[0].vld   = accept && operation && !goal_done && (node_count != '0)
                     && (node_count != CNT_W'(MAX_NODES));
    chain[0].px    = point_x;
    chain[0].py    = point_y;
    chain[0].bestd = nearest_limit;
    chain[0].best  = '0;
  end

  for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
    ptng_cell #(.INDEX(i)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .enable (node_count > CNT_W'(i)),
      .wr_en  ((root_wr && i == 0) || (leaf_wr && leaf == IDX_W'(i))),
      .wr_x   (root_wr ? point_x : sx),
      .wr_y   (root_wr ? point_y : sy),
      .prev   (chain[i]),
      .nxt    (chain[i+1])
    );
  end

  always_comb begin
    ram_we    = root_wr || leaf_wr;
    ram_waddr = root_wr ? '0 : leaf;
    ram_wdata = root_wr ? {point_x, point_y, {IDX_W{1'b0}}}
                        : {sx, sy, chain[MAX_NODES].best[IDX_W-1:0]};
  end

  ptng_ram #(.WIDTH(RAM_W), .DEPTH(MAX_NODES)) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (walk_i),
    .rd_data (ram_rdata)
  );

  always_comb begin
    gdx       = 16'(sx) - 16'(goal_x);
    gdy       = 16'(sy) - 16'(goal_y);
    gdist     = {1'b0, (gdx[15] ? 16'(-gdx) : 16'(gdx))}
              + {1'b0, (gdy[15] ? 16'(-gdy) : 16'(gdy))};
    goal_hit  = gdist < {2'b00, goal_radius};
    rd_parent = ram_rdata[IDX_W-1:0];
    n_plus    = {1'b0, n_out} + (CNT_W+1)'(1);
    path_end  = (rd_parent == '0) || (rd_parent >= walk_i)
             || (n_plus >= (CNT_W+1)'(MAX_NODES));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x        <= '0;
      goal_y        <= '0;
      goal_radius   <= GOAL_RADIUS_RESET;
      nearest_limit <= NEAREST_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GOAL_X:        goal_x <= cfg_data[14:0];
        REG_GOAL_Y:        goal_y <= cfg_data[14:0];
        REG_GOAL_RADIUS:   goal_radius <= cfg_data[14:0];
        REG_NEAREST_LIMIT: nearest_limit <= cfg_data;
        default:           goal_x <= goal_x;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= '0;
      goal_done  <= 1'b0;
      out_valid  <= 1'b0;
      walk_more  <= 1'b0;
      walk_i     <= '0;
      n_out      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            sx           <= point_x;
            sy           <= point_y;
            node_index   <= '0;
            parent_index <= '0;
            node_x       <= operation ? '0 : point_x;
            node_y       <= operation ? '0 : point_y;
            goal_reached <= 1'b0;
            last         <= 1'b1;
            walk_more    <= 1'b0;
            if (!operation) begin
              kind       <= KIND_ROOT;
              node_count <= CNT_W'(1);
              goal_done  <= 1'b0;
              out_valid  <= 1'b1;
              state      <= S_EMIT;
            end else if (goal_done || node_count == '0) begin
              kind      <= KIND_IGNORED;
              out_valid <= 1'b1;
              state     <= S_EMIT;
            end else if (node_count == CNT_W'(MAX_NODES)) begin
              kind      <= KIND_FULL;
              out_valid <= 1'b1;
              state     <= S_EMIT;
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (chain[MAX_NODES].vld) begin
            kind         <= KIND_ADDED;
            node_index   <= 6'(leaf);
            parent_index <= chain[MAX_NODES].best;
            node_x       <= sx;
            node_y       <= sy;
            goal_reached <= goal_hit;
            last         <= !goal_hit;
            node_count   <= node_count + CNT_W'(1);
            walk_i       <= leaf;
            walk_more    <= goal_hit;
            n_out        <= CNT_W'(1);
            if (goal_hit) begin
              goal_done <= 1'b1;
            end
            out_valid <= 1'b1;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= walk_more ? S_RD : S_IDLE;
          end
        end
        S_RD: begin
          state <= S_DATA;
        end
        S_DATA: begin
          kind         <= KIND_PATH;
          node_index   <= 6'(walk_i);
          parent_index <= 6'(rd_parent);
          node_x       <= ram_rdata[RAM_W-1 -: 15];
          node_y       <= ram_rdata[RAM_W-16 -: 15];
          goal_reached <= 1'b1;
          last         <= path_end;
          walk_more    <= !path_end;
          walk_i       <= rd_parent;
          n_out        <= n_plus[CNT_W-1:0];
          out_valid    <= 1'b1;
          state        <= S_EMIT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/ptng_checker.sv]
// Port-level checker of the planning tree nearest-grow block, with its bind
`default_nettype none
`include "planning_tree_nearest_grow_core_macros.svh"
module ptng_checker (
  input logic              clk,
  input logic              rst,
  input logic              cfg_we,
  input logic [1:0]        cfg_index,
  input logic [15:0]       cfg_data,
  input logic              in_valid,
  input logic              in_ready,
  input logic              operation,
  input ptng_pkg::coord_t  point_x,
  input ptng_pkg::coord_t  point_y,
  input logic              out_valid,
  input logic              out_ready,
  input ptng_pkg::kind_t   kind,
  input logic [5:0]        node_index,
  input logic [5:0]        parent_index,
  input ptng_pkg::coord_t  node_x,
  input ptng_pkg::coord_t  node_y,
  input logic              goal_reached,
  input logic              last
);
  import ptng_pkg::*;

  `PTNG_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(kind) && $stable(node_index) && $stable(last))
  `PTNG_ASSERT_NOW(a_one_in_flight, clk, rst, in_valid && in_ready, !out_valid)
  `PTNG_ASSERT_NOW(a_root_shape, clk, rst, out_valid && kind == KIND_ROOT,
    last && node_index == 6'd0 && parent_index == 6'd0 && !goal_reached)
  `PTNG_ASSERT_NOW(a_reject_zero, clk, rst,
    out_valid && (kind == KIND_IGNORED || kind == KIND_FULL),
    last && node_x == '0 && node_y == '0 && !goal_reached)
  `PTNG_ASSERT_NOW(a_path_goal, clk, rst, out_valid && kind == KIND_PATH,
    goal_reached && node_index != 6'd0)
endmodule

bind planning_tree_nearest_grow_core ptng_checker u_ptng_checker (.*);
`default_nettype wire
